// ----- src/tcw_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the console writer
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int CELLS     = ROWS * COLUMNS;
	localparam int SCROLL_AT = (ROWS - 1) * COLUMNS;
	localparam int COPY_LEN  = (ROWS - 2) * COLUMNS;

	// internal widths
	localparam int CUR_W  = $clog2(CELLS + 1);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int POS_W  = CUR_W + 2;

	// fixed field widths
	localparam int KIND_W   = 2;
	localparam int CODE_W   = 9;
	localparam int DELTA_W  = 10;
	localparam int CADDR_W  = 11;
	localparam int OCUR_W   = 11;
	localparam int CELL_W   = 16;
	localparam int ATTR_W   = 8;
	localparam int CHAR_W   = 8;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	// reciprocal of the row length for the column lookup
	localparam int RECIP_SH = 16;
	localparam int RECIP    = (1 << RECIP_SH) / COLUMNS;
	localparam int PROD_W   = CUR_W + RECIP_SH + 1;

	// signed position constants
	localparam logic signed [POS_W-1:0] POS_ONE    = POS_W'(1);
	localparam logic signed [POS_W-1:0] POS_COLS   = POS_W'(COLUMNS);
	localparam logic signed [POS_W-1:0] POS_CELLS  = POS_W'(CELLS);
	localparam logic signed [POS_W-1:0] POS_SCROLL = POS_W'(SCROLL_AT);

	// item kinds
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

	// character codes
	localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
	localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'd256;
	localparam logic [CHAR_W-1:0] CODE_BLANK     = 8'h20;

	// register map: index is paddr[2]
	localparam logic REG_ATTR = 1'b0;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_COPY,
		S_WIPE,
		S_BLANK
	} state_t;

	typedef struct packed {
		logic latch;
		logic clear;
		logic exec;
		logic copy;
		logic wipe;
		logic blank;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic step_item;
		logic bad_pos;
		logic scroll;
		logic blank;
		logic clear_done;
		logic copy_done;
		logic wipe_done;
	} status_t;

endpackage

// ----- src/tcw_datapath.sv -----
// datapath: item registers, cursor, error flag, cell store, sweep counter and result register
module tcw_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tcw_pkg::cmd_t                       cmd,
	output tcw_pkg::status_t                    st,
	input  logic [tcw_pkg::ATTR_W-1:0]          attr,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CODE_W-1:0]          char_code,
	input  logic signed [tcw_pkg::DELTA_W-1:0]  move_delta,
	input  logic [tcw_pkg::CADDR_W-1:0]         cell_address,
	input  logic                                blank_after,
	output logic [tcw_pkg::OCUR_W-1:0]          cursor_pos,
	output logic                                position_error,
	output logic [tcw_pkg::CELL_W-1:0]          cell_data
);

	// item registers
	logic [tcw_pkg::KIND_W-1:0]         kind_q;
	logic [tcw_pkg::CODE_W-1:0]         code_q;
	logic signed [tcw_pkg::DELTA_W-1:0] delta_q;
	logic [tcw_pkg::CADDR_W-1:0]        addr_q;
	logic                               blank_q;

	// control state
	logic [tcw_pkg::CUR_W-1:0]  cursor_q;
	logic                       halted_q;
	logic [tcw_pkg::CUR_W-1:0]  cnt_q;
	logic                       copy_v_s1;

	// payload state
	logic [tcw_pkg::ADDR_W-1:0] copy_a_s1;
	logic [tcw_pkg::CUR_W-1:0]  pos_q;
	logic [tcw_pkg::PROD_W-1:0] prod_q;
	logic                       res_rd_q;

	// cell store
	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
	logic [tcw_pkg::CELL_W-1:0] rd_q;
	logic                       we;
	logic [tcw_pkg::ADDR_W-1:0] wa;
	logic [tcw_pkg::CELL_W-1:0] wd;
	logic                       re;
	logic [tcw_pkg::ADDR_W-1:0] ra;

	// execute-step signals
	logic [tcw_pkg::CUR_W-1:0]        row_est;
	logic [tcw_pkg::CUR_W-1:0]        row_base;
	logic [tcw_pkg::CUR_W-1:0]        rem0;
	logic [tcw_pkg::CUR_W-1:0]        col;
	logic signed [tcw_pkg::POS_W-1:0] cur_s;
	logic signed [tcw_pkg::POS_W-1:0] col_s;
	logic signed [tcw_pkg::POS_W-1:0] delta_s;
	logic signed [tcw_pkg::POS_W-1:0] pos;
	logic                             step_item;
	logic                             bad_pos;
	logic                             scroll;
	logic                             char_wr;
	logic                             rd_hit;
	logic                             wipe_done;
	logic                             copy_done;
	logic [tcw_pkg::ADDR_W-1:0]       cur_a;
	logic [tcw_pkg::ADDR_W-1:0]       cnt_a;

	assign cur_a = cursor_q[tcw_pkg::ADDR_W-1:0];
	assign cnt_a = cnt_q[tcw_pkg::ADDR_W-1:0];

	// row estimate of the cursor, one register behind the cursor
	always_ff @(posedge clk) begin
		prod_q <= tcw_pkg::PROD_W'(cursor_q) * tcw_pkg::PROD_W'(tcw_pkg::RECIP);
	end

	// column of the cursor: estimate is exact or one row short
	always_comb begin
		row_est  = tcw_pkg::CUR_W'(prod_q >> tcw_pkg::RECIP_SH);
		row_base = tcw_pkg::CUR_W'(row_est * tcw_pkg::CUR_W'(tcw_pkg::COLUMNS));
		rem0     = cursor_q - row_base;
		col      = (rem0 >= tcw_pkg::CUR_W'(tcw_pkg::COLUMNS)) ?
			rem0 - tcw_pkg::CUR_W'(tcw_pkg::COLUMNS) : rem0;
	end

	// next cursor position for a character or move item
	always_comb begin
		cur_s   = $signed(tcw_pkg::POS_W'(cursor_q));
		col_s   = $signed(tcw_pkg::POS_W'(col));
		delta_s = tcw_pkg::POS_W'(delta_q);
		pos     = cur_s;
		case (kind_q)
			tcw_pkg::KIND_CHAR: begin
				if (code_q == tcw_pkg::CODE_NEWLINE) begin
					pos = cur_s + tcw_pkg::POS_COLS - col_s;
				end else if (code_q == tcw_pkg::CODE_BACKSPACE) begin
					if (cursor_q != '0) begin
						pos = cur_s - tcw_pkg::POS_ONE;
					end
				end else begin
					pos = cur_s + tcw_pkg::POS_ONE;
				end
			end
			tcw_pkg::KIND_MOVE: pos = cur_s + delta_s;
			default:            pos = cur_s;
		endcase
	end

	// item classification and sweep status
	always_comb begin
		step_item = !halted_q && (kind_q inside {tcw_pkg::KIND_CHAR, tcw_pkg::KIND_MOVE});
		bad_pos   = (pos < 0) || (pos > tcw_pkg::POS_CELLS);
		scroll    = pos >= tcw_pkg::POS_SCROLL;
		char_wr   = step_item && (kind_q == tcw_pkg::KIND_CHAR) &&
			(code_q != tcw_pkg::CODE_NEWLINE) && (code_q != tcw_pkg::CODE_BACKSPACE) &&
			(cursor_q < tcw_pkg::CUR_W'(tcw_pkg::CELLS));
		rd_hit    = !halted_q && (kind_q == tcw_pkg::KIND_READ) &&
			(addr_q < tcw_pkg::CADDR_W'(tcw_pkg::CELLS));
		wipe_done = cnt_q >= tcw_pkg::CUR_W'(tcw_pkg::SCROLL_AT);
		copy_done = cnt_q == tcw_pkg::CUR_W'(tcw_pkg::COPY_LEN);
	end

	assign st.step_item  = step_item;
	assign st.bad_pos    = bad_pos;
	assign st.scroll     = scroll;
	assign st.blank      = blank_q;
	assign st.clear_done = cnt_q == tcw_pkg::CUR_W'(tcw_pkg::CELLS - 1);
	assign st.copy_done  = copy_done;
	assign st.wipe_done  = wipe_done;

	// cell store port selection
	always_comb begin
		we = 1'b0;
		wa = cnt_a;
		wd = '0;
		re = 1'b0;
		ra = tcw_pkg::ADDR_W'(addr_q);
		if (cmd.clear) begin
			we = 1'b1;
		end else if (cmd.exec) begin
			we = char_wr;
			wa = cur_a;
			wd = {attr, code_q[tcw_pkg::CHAR_W-1:0]};
		end else if (copy_v_s1) begin
			we = 1'b1;
			wa = copy_a_s1;
			wd = rd_q;
		end else if (cmd.wipe) begin
			we = !wipe_done;
		end else if (cmd.blank) begin
			we = cursor_q < tcw_pkg::CUR_W'(tcw_pkg::CELLS);
			wa = cur_a;
			wd = {attr, tcw_pkg::CODE_BLANK};
		end
		if (cmd.exec) begin
			re = rd_hit;
		end else if (cmd.copy) begin
			re = !copy_done;
			ra = tcw_pkg::ADDR_W'(cnt_q + tcw_pkg::CUR_W'(tcw_pkg::COLUMNS));
		end
	end

	// cell store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	// cursor, error flag, sweep counter, copy write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			halted_q  <= 1'b0;
			cnt_q     <= '0;
			copy_v_s1 <= 1'b0;
		end else begin
			copy_v_s1 <= cmd.copy && !copy_done;
			if (cmd.clear) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.exec) begin
				if (step_item) begin
					if (bad_pos) begin
						halted_q <= 1'b1;
					end else if (scroll) begin
						cnt_q <= '0;
					end else begin
						cursor_q <= tcw_pkg::CUR_W'(pos);
					end
				end
			end else if (cmd.copy) begin
				cnt_q <= copy_done ? pos_q : cnt_q + 1'b1;
			end else if (cmd.wipe) begin
				if (wipe_done) begin
					cursor_q <= pos_q;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// item capture, scroll target, copy address stage, result register
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= kind;
			code_q  <= char_code;
			delta_q <= move_delta;
			addr_q  <= cell_address;
			blank_q <= blank_after;
		end
		if (cmd.exec) begin
			res_rd_q <= rd_hit;
			pos_q    <= tcw_pkg::CUR_W'(pos - tcw_pkg::POS_COLS);
		end
		copy_a_s1 <= cnt_a;
		if (cmd.load_out) begin
			cursor_pos     <= tcw_pkg::OCUR_W'(cursor_q);
			position_error <= halted_q;
			cell_data      <= res_rd_q ? rd_q : '0;
		end
	end

	// error flag is sticky
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("error flag dropped");

	// cursor never beyond the end of the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= tcw_pkg::CUR_W'(tcw_pkg::CELLS))
		else $error("cursor out of range");

	// copy write-back only inside the scroll sweep
	a_copy_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		copy_v_s1 |-> cmd.copy)
		else $error("copy write outside scroll");

endmodule

// ----- src/tcw_ctrl.sv -----
// controller: sequences clearing pass, item steps, scroll sweeps and result handoff
module tcw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  tcw_pkg::status_t st,
	output tcw_pkg::cmd_t    cmd
);

	tcw_pkg::state_t state_q;
	tcw_pkg::state_t state_d;
	logic            pend_q;
	logic            pend_d;
	logic            out_valid_q;
	logic            out_valid_d;
	logic            out_free;
	logic            stall;
	logic            finish;

	// state and handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::S_CLEAR;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		out_free = !out_valid_q || !out_stall;
		stall    = 1'b1;
		case (state_q)
			tcw_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clear_done) begin
					state_d = tcw_pkg::S_IDLE;
				end
			end
			tcw_pkg::S_IDLE: begin
				cmd.load_out = pend_q && out_free;
				stall        = pend_q && !out_free;
				if (in_valid && !stall) begin
					cmd.latch = 1'b1;
					state_d   = tcw_pkg::S_EXEC;
				end
			end
			tcw_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				if (st.step_item && !st.bad_pos && st.scroll) begin
					state_d = tcw_pkg::S_COPY;
				end else if (st.step_item && !st.bad_pos && st.blank) begin
					state_d = tcw_pkg::S_BLANK;
				end else begin
					state_d = tcw_pkg::S_IDLE;
				end
			end
			tcw_pkg::S_COPY: begin
				cmd.copy = 1'b1;
				if (st.copy_done) begin
					state_d = tcw_pkg::S_WIPE;
				end
			end
			tcw_pkg::S_WIPE: begin
				cmd.wipe = 1'b1;
				if (st.wipe_done) begin
					state_d = st.blank ? tcw_pkg::S_BLANK : tcw_pkg::S_IDLE;
				end
			end
			tcw_pkg::S_BLANK: begin
				cmd.blank = 1'b1;
				state_d   = tcw_pkg::S_IDLE;
			end
			default: begin
				state_d = tcw_pkg::S_IDLE;
			end
		endcase
		finish      = (state_d == tcw_pkg::S_IDLE) &&
			(state_q inside {tcw_pkg::S_EXEC, tcw_pkg::S_WIPE, tcw_pkg::S_BLANK});
		pend_d      = finish || (pend_q && !cmd.load_out);
		out_valid_d = cmd.load_out || (out_valid_q && out_stall);
	end

	assign in_stall  = stall;
	assign out_valid = out_valid_q;

	// a finished result waits while the output beat is stalled
	a_pend_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::S_IDLE && pend_q && out_valid_q && out_stall) |=> pend_q)
		else $error("pending result lost");

	// one execute step per item
	a_one_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::S_EXEC) |=> (state_q != tcw_pkg::S_EXEC))
		else $error("repeated execute step");

	// no result waits while a scroll runs
	a_scroll_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::S_COPY || state_q == tcw_pkg::S_WIPE) |-> !pend_q)
		else $error("result pending during scroll");

	// scroll copy hands over to the wipe sweep
	a_copy_to_wipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::S_COPY && st.copy_done) |=> (state_q == tcw_pkg::S_WIPE))
		else $error("copy sweep did not end in wipe");

endmodule

// ----- src/text_console_cursor_writer.sv -----
// top level: text console writer with attribute register on an APB-style port
//
// Input channel (in_valid/in_stall) takes one item per beat: a character, a cursor
// move, or a cell read. Output channel (out_valid/out_stall) returns one beat per item
// with the cursor after the item, the sticky position error and the read cell (else 0).
// Steps: a character or move item without scroll, and a read item, pass through latch
// and execute; a blank cell adds a blank step. Items are taken one at a time. The cell
// store has one write port, so a scroll copies one cell per cycle: a scroll adds a copy
// sweep of (ROWS-2)*COLUMNS = 1840 cells, then a wipe of the rest of the last text row.
// The result leaves through an output register; the next item is accepted while the
// result is still offered, and held off while an item runs or a result waits to go out.
// Reset: the cursor and error flag clear, attribute goes to 7, and the cell store is
// cleared one cell per cycle, all CELLS = 2000 cells, with in_stall high meanwhile.
// Once a step would take the cursor outside 0..CELLS it stays put; later items only report it with the error set.
// The attribute register sits at byte address 0; writes land on the access cycle.
module text_console_cursor_writer (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CODE_W-1:0]          char_code,
	input  logic signed [tcw_pkg::DELTA_W-1:0]  move_delta,
	input  logic [tcw_pkg::CADDR_W-1:0]         cell_address,
	input  logic                                blank_after,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tcw_pkg::OCUR_W-1:0]          cursor_pos,
	output logic                                position_error,
	output logic [tcw_pkg::CELL_W-1:0]          cell_data,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tcw_pkg::APB_AW-1:0]          paddr,
	input  logic [tcw_pkg::APB_DW-1:0]          pwdata,
	output logic [tcw_pkg::APB_DW-1:0]          prdata,
	output logic                                pready
);

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	tcw_pkg::cmd_t              cmd;
	tcw_pkg::status_t           st;

	// attribute register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && paddr[2] == tcw_pkg::REG_ATTR) begin
			attr_q <= pwdata[tcw_pkg::ATTR_W-1:0];
		end
	end

	// register readback, no wait states
	assign prdata = (paddr[2] == tcw_pkg::REG_ATTR) ? tcw_pkg::APB_DW'(attr_q) : '0;
	assign pready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	tcw_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.attr           (attr_q),
		.kind           (kind),
		.char_code      (char_code),
		.move_delta     (move_delta),
		.cell_address   (cell_address),
		.blank_after    (blank_after),
		.cursor_pos     (cursor_pos),
		.position_error (position_error),
		.cell_data      (cell_data)
	);

endmodule

// ----- verif/console_checker.sv -----
// checker for the console writer: predicts each result beat and compares it with the block
`timescale 1ns / 1ps

module console_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CODE_W-1:0]          char_code,
	input  logic signed [tcw_pkg::DELTA_W-1:0]  move_delta,
	input  logic [tcw_pkg::CADDR_W-1:0]         cell_address,
	input  logic                                blank_after,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [tcw_pkg::OCUR_W-1:0]          cursor_pos,
	input  logic                                position_error,
	input  logic [tcw_pkg::CELL_W-1:0]          cell_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tcw_pkg::APB_AW-1:0]          paddr,
	input  logic [tcw_pkg::APB_DW-1:0]          pwdata,
	input  logic                                pready,
	output int                                  mismatches,
	output int                                  pending
);
	import tcw_pkg::*;

	typedef struct packed {
		logic [OCUR_W-1:0] cursor;
		logic              halted;
		logic [CELL_W-1:0] cell_word;
	} console_beat_t;

	// shadow of the screen, cursor, error flag and attribute
	logic [CELL_W-1:0] screen [0:CELLS-1];
	int                cursor;
	logic              halted;
	logic [ATTR_W-1:0] attr;
	console_beat_t     expected_beats[$];
	int                fail_count;

	task automatic put_cell(input int at, input logic [CHAR_W-1:0] ch);
		if (at >= 0 && at < CELLS) begin
			screen[at] = {attr, ch};
		end
	endtask

	// apply one item to the shadow state and return the beat it should produce
	task automatic console_step(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] code,
			input logic signed [DELTA_W-1:0] delta, input logic [CADDR_W-1:0] addr,
			input logic blank, output console_beat_t beat);
		int pos;
		logic [CELL_W-1:0] data;
		data = '0;
		if (!halted) begin
			if (k == KIND_CHAR || k == KIND_MOVE) begin
				pos = cursor;
				if (k == KIND_MOVE) begin
					pos = pos + int'(delta);
				end else if (code == CODE_NEWLINE) begin
					pos = pos + COLUMNS - pos % COLUMNS;
				end else if (code == CODE_BACKSPACE) begin
					if (pos > 0)
						pos = pos - 1;
				end else begin
					put_cell(pos, code[CHAR_W-1:0]);
					pos = pos + 1;
				end
				if (pos < 0 || pos > CELLS) begin
					halted = 1'b1;
				end else begin
					// bottom row reached: scroll rows up, step back, wipe rest of last text row
					if (pos >= SCROLL_AT) begin
						for (int i = 0; i < COPY_LEN; i++)
							screen[i] = screen[i + COLUMNS];
						pos = pos - COLUMNS;
						for (int i = pos; i < SCROLL_AT; i++)
							screen[i] = '0;
					end
					cursor = pos;
					if (blank)
						put_cell(cursor, CODE_BLANK);
				end
			end else if (k == KIND_READ && addr < CELLS) begin
				data = screen[addr];
			end
		end
		beat.cursor    = cursor[OCUR_W-1:0];
		beat.halted    = halted;
		beat.cell_word = data;
	endtask

	always @(posedge clk or negedge arst_n) begin
		console_beat_t want;
		console_beat_t got;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = '0;
			cursor = 0;
			halted = 1'b0;
			attr = ATTR_RESET;
			expected_beats.delete();
			fail_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// result beat against the oldest expectation
			if (out_valid && !out_stall) begin
				got = '{cursor_pos, position_error, cell_data};
				if (expected_beats.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat cursor_pos %0d position_error %0d cell_data %h",
						$time, cursor_pos, position_error, cell_data);
				end else begin
					want = expected_beats.pop_front();
					if (got.cursor !== want.cursor) begin
						fail_count++;
						$display("%0t: cursor_pos expected %0d actual %0d",
							$time, want.cursor, got.cursor);
					end
					if (got.halted !== want.halted) begin
						fail_count++;
						$display("%0t: position_error expected %0d actual %0d",
							$time, want.halted, got.halted);
					end
					if (got.cell_word !== want.cell_word) begin
						fail_count++;
						$display("%0t: cell_data expected %h actual %h",
							$time, want.cell_word, got.cell_word);
					end
				end
			end
			// attribute register write
			if (psel && penable && pwrite && pready && paddr[2] == REG_ATTR)
				attr = pwdata[ATTR_W-1:0];
			// item beat
			if (in_valid && !in_stall) begin
				console_step(kind, char_code, move_delta, cell_address, blank_after, want);
				expected_beats.push_back(want);
			end
			mismatches <= fail_count;
			pending <= expected_beats.size();
		end
	end

endmodule

// ----- verif/tb_text_console_cursor_writer.sv -----
// testbench top for the console writer: clock, reset, item and register stimulus, verdict
`timescale 1ns / 1ps

module tb_text_console_cursor_writer;
	import tcw_pkg::*;

	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;
	localparam logic [APB_AW-1:0] ADDR_ATTR   = {REG_ATTR, 2'b00};
	localparam int                QUIET_LIMIT = 20000;
	localparam int                PHASE_ITEMS = 550;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [KIND_W-1:0]           kind;
	logic [CODE_W-1:0]           char_code;
	logic signed [DELTA_W-1:0]   move_delta;
	logic [CADDR_W-1:0]          cell_address;
	logic                        blank_after;
	logic                        out_valid;
	logic                        out_stall;
	logic [OCUR_W-1:0]           cursor_pos;
	logic                        position_error;
	logic [CELL_W-1:0]           cell_data;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [APB_AW-1:0]           paddr;
	logic [APB_DW-1:0]           pwdata;
	logic [APB_DW-1:0]           prdata;
	logic                        pready;
	int                          mismatches;
	int                          pending;

	// idle rates in percent, per side
	int send_idle_pct;
	int recv_idle_pct;
	// cursor as the stimulus sees it, used to steer moves
	int   track_cursor;
	logic track_halted;

	text_console_cursor_writer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .char_code(char_code),
		.move_delta(move_delta), .cell_address(cell_address), .blank_after(blank_after),
		.out_valid(out_valid), .out_stall(out_stall), .cursor_pos(cursor_pos),
		.position_error(position_error), .cell_data(cell_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	console_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .char_code(char_code),
		.move_delta(move_delta), .cell_address(cell_address), .blank_after(blank_after),
		.out_valid(out_valid), .out_stall(out_stall), .cursor_pos(cursor_pos),
		.position_error(position_error), .cell_data(cell_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
	end

	// watchdog: too long without any beat on either channel
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// follow the cursor so that moves can be kept in range
	task automatic follow_cursor(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] code,
			input int delta);
		int pos;
		pos = track_cursor;
		if (!track_halted && (k == KIND_CHAR || k == KIND_MOVE)) begin
			if (k == KIND_MOVE)
				pos = pos + delta;
			else if (code == CODE_NEWLINE)
				pos = pos + COLUMNS - pos % COLUMNS;
			else if (code == CODE_BACKSPACE)
				pos = (pos > 0) ? pos - 1 : pos;
			else
				pos = pos + 1;
			if (pos < 0 || pos > CELLS) begin
				track_halted = 1'b1;
			end else begin
				if (pos >= SCROLL_AT)
					pos = pos - COLUMNS;
				track_cursor = pos;
			end
		end
	endtask

	// offer one item beat and hold it until taken
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] code,
			input int delta, input logic [CADDR_W-1:0] addr, input logic blank);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		char_code    <= code;
		move_delta   <= DELTA_W'(delta);
		cell_address <= addr;
		blank_after  <= blank;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		follow_cursor(k, code, delta);
	endtask

	// drop valid and wait until every result beat is back
	task automatic drain;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_attr(input logic [ATTR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ATTR;
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random mix; moves stay in range and lean upward near the bottom of the screen
	task automatic random_phase(input int count, input int send_pct, input int recv_pct);
		int taken;
		int sel;
		int lo;
		int hi;
		int delta;
		logic [KIND_W-1:0]  k;
		logic [CODE_W-1:0]  code;
		logic [CADDR_W-1:0] addr;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		taken = 0;
		while (taken < count) begin
			sel   = $urandom_range(99, 0);
			code  = CODE_W'($urandom_range(511, 0));
			delta = $urandom_range(1023, 0) - 512;
			addr  = CADDR_W'($urandom_range(2047, 0));
			if (sel < 45) begin
				k = KIND_CHAR;
				case ($urandom_range(11, 0))
					0: code = CODE_NEWLINE;
					1: code = CODE_BACKSPACE;
					default: ;
				endcase
			end else if (sel < 65) begin
				k  = KIND_MOVE;
				lo = (track_cursor < 512) ? -track_cursor : -512;
				hi = (CELLS - track_cursor < 511) ? CELLS - track_cursor : 511;
				if (track_cursor > 1400 && hi > 40)
					hi = 40;
				delta = lo + int'($urandom_range(hi - lo, 0));
			end else if (sel < 95) begin
				k = KIND_READ;
				case ($urandom_range(15, 0))
					0: addr = CADDR_W'($urandom_range(2047, CELLS));
					1, 2, 3, 4, 5, 6, 7: addr = CADDR_W'((track_cursor > 160) ?
						track_cursor - $urandom_range(160, 0) : $urandom_range(160, 0));
					default: addr = CADDR_W'($urandom_range(CELLS - 1, 0));
				endcase
			end else begin
				k = KIND_NONE;
			end
			send_item(k, code, delta, addr, ($urandom_range(3, 0) == 0));
			if (k != KIND_NONE)
				taken++;
		end
	endtask

	initial begin
		int dir;
		int delta;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		kind          <= KIND_CHAR;
		char_code     <= '0;
		move_delta    <= '0;
		cell_address  <= '0;
		blank_after   <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		send_idle_pct = 11;
		recv_idle_pct = 50;
		track_cursor  = 0;
		track_halted  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, newline, backspace at zero, scrolls, out-of-range read
		send_item(KIND_READ, '0, 0, 11'd0, 1'b0);
		send_item(KIND_CHAR, CODE_BACKSPACE, 0, '0, 1'b0);
		send_item(KIND_CHAR, 9'h041, 0, '0, 1'b0);
		send_item(KIND_CHAR, 9'h000, 0, '0, 1'b0);
		send_item(KIND_CHAR, 9'h0ff, 0, '0, 1'b1);
		send_item(KIND_CHAR, 9'h101, 0, '0, 1'b0);
		send_item(KIND_CHAR, 9'h1ff, 0, '0, 1'b0);
		send_item(KIND_CHAR, CODE_NEWLINE, 0, '0, 1'b0);
		send_item(KIND_CHAR, CODE_BACKSPACE, 0, '0, 1'b0);
		send_item(KIND_CHAR, CODE_NEWLINE, 0, '0, 1'b1);
		send_item(KIND_MOVE, '0, 511, '0, 1'b0);
		send_item(KIND_MOVE, '0, -512, '0, 1'b0);
		repeat (3) send_item(KIND_MOVE, '0, 511, '0, 1'b0);
		// land exactly on the bottom row, then newline on the last text row
		send_item(KIND_MOVE, '0, 308, '0, 1'b0);
		send_item(KIND_CHAR, CODE_NEWLINE, 0, '0, 1'b0);
		// scroll with a partial wipe, then move to the very last position
		send_item(KIND_MOVE, '0, 100, '0, 1'b1);
		send_item(KIND_MOVE, '0, 140, '0, 1'b0);
		send_item(KIND_CHAR, 9'h05a, 0, '0, 1'b0);
		send_item(KIND_READ, '0, 0, 11'd1920, 1'b0);
		send_item(KIND_READ, '0, 0, 11'd2047, 1'b0);
		send_item(KIND_READ, '0, 0, 11'd1999, 1'b1);
		send_item(KIND_NONE, 9'h1ff, -1, 11'h7ff, 1'b1);
		send_item(KIND_READ, '0, 0, 11'd2, 1'b1);
		drain();

		write_attr(8'hff);
		random_phase(PHASE_ITEMS, 11, 50);
		drain();
		write_attr(8'h00);
		random_phase(PHASE_ITEMS, 50, 11);
		drain();
		write_attr(ATTR_W'($urandom_range(255, 0)));
		random_phase(PHASE_ITEMS, 0, 0);

		// push the cursor off the screen in a random direction, then items while halted
		dir = $urandom_range(1, 0);
		while (!track_halted) begin
			if (dir == 0)
				delta = (track_cursor < 512) ? -int'($urandom_range(512, track_cursor + 1)) : -512;
			else
				delta = (track_cursor >= 1490) ? int'($urandom_range(511, 2001 - track_cursor)) : 511;
			send_item(KIND_MOVE, '0, delta, '0, 1'b0);
		end
		send_item(KIND_READ, '0, 0, 11'd0, 1'b0);
		send_item(KIND_CHAR, 9'h041, 0, '0, 1'b1);
		send_item(KIND_MOVE, '0, -1, '0, 1'b0);
		send_item(KIND_CHAR, CODE_NEWLINE, 0, '0, 1'b0);
		send_item(KIND_READ, '0, 0, 11'd1920, 1'b1);
		send_item(KIND_NONE, '0, 0, '0, 1'b0);
		drain();
		repeat (10) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- text_console_cursor_writer.f -----
src/tcw_pkg.sv
src/tcw_datapath.sv
src/tcw_ctrl.sv
src/text_console_cursor_writer.sv
verif/console_checker.sv
verif/tb_text_console_cursor_writer.sv
